@@ sv/sba_pkg.sv @@
// types, constants and helpers shared by the slab block allocator
`timescale 1ns / 1ps

package sba_pkg;

  localparam int SLAB_BYTES    = 8192;
  localparam int TYPE_COUNT    = 4;
  localparam int NUM_SIZE_REGS = 4;

  localparam int SIZE_W   = 14;
  localparam int OFFSET_W = 13;
  localparam int FREE_W   = 16;
  localparam int ATYPE_W  = 3;
  localparam int CFG_IDX_W = 3;

  localparam int ROW_W         = 16;
  localparam int ROW_SHIFT     = $clog2(ROW_W);
  localparam int ROWS_PER_TYPE = (SLAB_BYTES + ROW_W - 1) / ROW_W;
  localparam int RAM_DEPTH     = TYPE_COUNT * ROWS_PER_TYPE;
  localparam int ADDR_W        = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
  localparam int CNT_W         = $clog2(SLAB_BYTES + (1 << SIZE_W));

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } sba_action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_TYPE = 2'd1,
    ST_OOM      = 2'd2,
    ST_BAD_FREE = 2'd3
  } sba_status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_TEST,
    S_OUT
  } sba_state_e;

  typedef struct packed {
    logic                action;
    logic [ATYPE_W-1:0]  alloc_type;
    logic [FREE_W-1:0]   free_offset;
  } sba_in_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [OFFSET_W-1:0] block_offset;
  } sba_out_t;

endpackage

@@ sv/sba_ram.sv @@
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module sba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/slab_block_allocator.sv @@
// slab block allocator top level: sequencer, size registers and flag store
//
// Usage: each input item is an allocate or free request for one partition.
// in_valid_i / in_stall_o carry requests, out_valid_o / out_stall_i carry
// one result item per request (status and block offset). Block sizes are
// set through cfg_we_i / cfg_idx_i / cfg_data_i while the block is idle.
// Used flags sit in a ram of 16-flag rows, one row read per cycle.
// Timing: a rejected request (bad type, zero or oversized block size, offset
// out of range) gives its result in the cycle after acceptance. A free
// passes S_READ, S_TEST and S_OUT. An allocate repeats S_READ and S_TEST
// once per block visited, at most SLAB_BYTES / block size blocks, then goes
// to S_OUT. One request is in flight at a time; the next is accepted
// in the cycle after its result is taken.
// After reset a clearing pass writes every flag row to zero (RAM_DEPTH
// rows, 2048 at the default sizes), with in_stall_o high; configuration
// writes are taken meanwhile. While out_stall_i is high the result is held
// and no new request is accepted.
`timescale 1ns / 1ps

module slab_block_allocator
  import sba_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sba_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sba_out_t             out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [SIZE_W-1:0]    cfg_data_i
);

  sba_state_e state_q, state_d;

  logic [SIZE_W-1:0]   size_q [NUM_SIZE_REGS];
  logic [ADDR_W-1:0]   clr_q, clr_d;
  logic [CNT_W-1:0]    pos_q, pos_d;
  logic [CNT_W-1:0]    end_q, end_d;
  logic [CNT_W-1:0]    next_end;
  logic [SIZE_W-1:0]   bsize_q, bsize_d;
  logic [ATYPE_W-1:0]  type_q, type_d;
  logic                act_q, act_d;
  sba_out_t            res_q, res_d;

  logic [SIZE_W-1:0]   req_size;
  logic [ADDR_W-1:0]   row_addr;
  logic [ROW_W-1:0]    rdata;
  logic [ROW_W-1:0]    bit_mask;
  logic                flag;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ROW_W-1:0]    ram_wdata;
  logic                in_acc;

  // size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_SIZE_REGS; k++) begin
        size_q[k] <= '0;
      end
    end else if (cfg_we_i && ({1'b0, cfg_idx_i} < (CFG_IDX_W + 1)'(NUM_SIZE_REGS))) begin
      size_q[cfg_idx_i[$clog2(NUM_SIZE_REGS)-1:0]] <= cfg_data_i;
    end
  end

  always_comb begin
    if ({1'b0, in_data_i.alloc_type} < (ATYPE_W + 1)'(NUM_SIZE_REGS)) begin
      req_size = size_q[in_data_i.alloc_type[$clog2(NUM_SIZE_REGS)-1:0]];
    end else begin
      req_size = '0;
    end
  end

  assign row_addr = ADDR_W'(ADDR_W'(type_q) * ADDR_W'(ROWS_PER_TYPE))
                  + ADDR_W'(pos_q >> ROW_SHIFT);
  assign bit_mask = ROW_W'(1) << pos_q[ROW_SHIFT-1:0];
  assign flag     = |(rdata & bit_mask);
  assign next_end = end_q + CNT_W'(bsize_q);
  assign in_acc   = in_valid_i && !in_stall_o;

  sba_ram #(
    .WIDTH(ROW_W),
    .DEPTH(RAM_DEPTH)
  ) u_flags (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(row_addr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    end_q   <= end_d;
    bsize_q <= bsize_d;
    type_q  <= type_d;
    act_q   <= act_d;
    res_q   <= res_d;
  end

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    pos_d      = pos_q;
    end_d      = end_q;
    bsize_d    = bsize_q;
    type_d     = type_q;
    act_d      = act_q;
    res_d      = res_q;
    ram_we     = 1'b0;
    ram_waddr  = row_addr;
    ram_wdata  = rdata;
    in_stall_o = 1'b1;
    out_valid_o = 1'b0;

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(RAM_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_acc) begin
          type_d  = in_data_i.alloc_type;
          act_d   = in_data_i.action;
          bsize_d = req_size;
          res_d.block_offset = '0;
          if ({1'b0, in_data_i.alloc_type} >= (ATYPE_W + 1)'(TYPE_COUNT)) begin
            res_d.status = ST_BAD_TYPE;
            state_d      = S_OUT;
          end else if (in_data_i.action == ACT_ALLOC) begin
            pos_d = '0;
            end_d = CNT_W'(req_size);
            if (req_size == '0 || CNT_W'(req_size) > CNT_W'(SLAB_BYTES)) begin
              res_d.status = ST_OOM;
              state_d      = S_OUT;
            end else begin
              state_d = S_READ;
            end
          end else begin
            pos_d = CNT_W'(in_data_i.free_offset);
            if ({1'b0, in_data_i.free_offset} >= (FREE_W + 1)'(SLAB_BYTES)) begin
              res_d.status = ST_BAD_FREE;
              state_d      = S_OUT;
            end else begin
              state_d = S_READ;
            end
          end
        end
      end
      S_READ: begin
        state_d = S_TEST;
      end
      S_TEST: begin
        if (act_q == ACT_ALLOC) begin
          if (!flag) begin
            ram_we             = 1'b1;
            ram_wdata          = rdata | bit_mask;
            res_d.status       = ST_OK;
            res_d.block_offset = OFFSET_W'(pos_q);
            state_d            = S_OUT;
          end else if (next_end > CNT_W'(SLAB_BYTES)) begin
            res_d.status       = ST_OOM;
            res_d.block_offset = '0;
            state_d            = S_OUT;
          end else begin
            pos_d   = end_q;
            end_d   = next_end;
            state_d = S_READ;
          end
        end else begin
          res_d.block_offset = '0;
          if (flag) begin
            ram_we       = 1'b1;
            ram_wdata    = rdata & ~bit_mask;
            res_d.status = ST_OK;
          end else begin
            res_d.status = ST_BAD_FREE;
          end
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_data_o = res_q;

endmodule
